/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, quiet while reset is low.
`define LCF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define LCF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  `LCF_ASSERT(lbl, clk, rst_n, (pre) |=> (post), msg)

`endif

/* rtl/core/lcf_pkg.sv */
// Types, constants and constant tables of the candle flicker block.
package lcf_pkg;

  localparam int ZONE_COUNT       = 16;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EFFECT_ON = 3'd0,
    REG_FLOOR     = 3'd1,
    REG_SWING     = 3'd2,
    REG_GAP       = 3'd3,
    REG_SEED      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TERM_MAIN  = 2'd0,
    TERM_FAST  = 2'd1,
    TERM_SLOW  = 2'd2,
    TERM_NOISE = 2'd3
  } term_t;

  localparam logic [7:0]  FLOOR_RST = 8'd20;
  localparam logic [7:0]  SWING_RST = 8'd100;
  localparam logic [9:0]  GAP_RST   = 10'd20;
  localparam logic [15:0] SEED_RST  = 16'd44257;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Flicker weights in Q15 and the noise weight in Q30 per unit.
  localparam logic [16:0] W_MAIN  = 17'd9830;
  localparam logic [16:0] W_FAST  = 17'd4915;
  localparam logic [16:0] W_SLOW  = 17'd6554;
  localparam logic [16:0] W_NOISE = 17'd107374;

  // Phase step while running: n = dt*speed*65536.
  localparam logic [63:0] RUN_MAIN_BIAS = 64'd100000;
  localparam logic [63:0] RUN_SLOW_BIAS = 64'd1000000;
  localparam logic [29:0] RUN_MAIN_DIV  = 30'd200000;
  localparam logic [29:0] RUN_SLOW_DIV  = 30'd2000000;
  localparam logic [63:0] FAST_MULT     = 64'd73;

  // Start phase from a draw p in hundredths of a radian.
  localparam logic [63:0] INIT_K_MAIN   = 64'd6553600000;
  localparam logic [63:0] INIT_K_FAST   = 64'd478412800000;
  localparam logic [63:0] INIT_K_SLOW   = 64'd26214400000;
  localparam logic [63:0] INIT_MAIN_BIAS = 64'd31415926;
  localparam logic [63:0] INIT_SLOW_BIAS = 64'd314159265;
  localparam logic [29:0] INIT_MAIN_DIV = 30'd62831853;
  localparam logic [29:0] INIT_SLOW_DIV = 30'd628318530;

  typedef struct packed {
    logic [3:0]  zone_slot;
    logic [7:0]  zone_tag;
    logic [31:0] now_ms;
    logic        zone_on;
    logic [7:0]  ceiling;
    logic [1:0]  zone_kind;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_tag;
    logic [7:0] level;
    logic       has_color;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef logic [14:0] sine_tab_t [SINE_TABLE_DEPTH+1];
  typedef logic [7:0]  byte_tab_t [256];

  // Quarter wave in Q1.15 from a ninth-order polynomial.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] s;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      z  = (64'(i) * 64'd65536) / SINE_TABLE_DEPTH;
      z2 = (z * z) >> 16;
      t  = 64'd172272;
      t  = 64'd5026995    - ((z2 * t) >> 16);
      t  = 64'd85569306   - ((z2 * t) >> 16);
      t  = 64'd693598667  - ((z2 * t) >> 16);
      t  = 64'd1686629713 - ((z2 * t) >> 16);
      s  = (((z * t) >> 16) + 64'd16384) >> 15;
      tab[i] = (s > 64'd32767) ? 15'h7FFF : s[14:0];
    end
    return tab;
  endfunction

  function automatic byte_tab_t build_green();
    byte_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 8'(60 + (i * 120) / 255);
    end
    return tab;
  endfunction

  function automatic byte_tab_t build_blue();
    byte_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 8'((i * 30) / 255);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB  = build_sine();
  localparam byte_tab_t GREEN_TAB = build_green();
  localparam byte_tab_t BLUE_TAB  = build_blue();

  // Signed Q1.15 sine of a 16-bit phase, one turn = 65536.
  function automatic logic signed [16:0] sine_q15(input logic [15:0] ph);
    int unsigned idx;
    logic [14:0] v;
    idx = (32'(ph[13:0]) * SINE_TABLE_DEPTH) >> 14;
    if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
    v = ph[14] ? SINE_TAB[SINE_TABLE_DEPTH - idx] : SINE_TAB[idx];
    return ph[15] ? -$signed({2'b00, v}) : $signed({2'b00, v});
  endfunction

endpackage

/* rtl/core/led_candle_flicker.sv */
// Candle flicker engine: per-zone phase, level and random pattern state.
// Each request is one update tick of one LED zone (0..15). An enabled zone is
// set up on its first tick after the effect is switched on and returns nothing
// then; later ticks that come at least update_gap_ms after the previous update
// return one result with the smoothed level (and a warm color for RGB zones)
// unless zone_kind bit 1 is set. Ticks while the effect or the zone is off,
// or before the gap has passed, return nothing and change nothing. One request
// is worked at a time; in_ready is high only between requests, while a
// finished result may still wait in the output register. All long arithmetic
// runs through one bit-serial divider of three lanes that retires one quotient
// bit per cycle, so it sets the pace of the random draws, the phase advance
// and the smoothing divide. A result that waits on out_ready adds its wait.
// A tick for an off zone or one before the gap has passed is dropped in the
// check state.
module led_candle_flicker import lcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [18:0] {
    ST_IDLE       = 19'h00001,
    ST_CHECK      = 19'h00002,
    ST_INIT_BASE  = 19'h00004,
    ST_INIT_PHASE = 19'h00008,
    ST_INIT_SPEED = 19'h00010,
    ST_INIT_REPAT = 19'h00020,
    ST_UPD_MUL    = 19'h00040,
    ST_PH_PREP    = 19'h00080,
    ST_PH_DIV     = 19'h00100,
    ST_NOISE      = 19'h00200,
    ST_SUM        = 19'h00400,
    ST_SCALE      = 19'h00800,
    ST_TARGET     = 19'h01000,
    ST_SMOOTH     = 19'h02000,
    ST_REP_BASE   = 19'h04000,
    ST_REP_SPEED  = 19'h08000,
    ST_REP_TIME   = 19'h10000,
    ST_FINISH     = 19'h20000,
    ST_EMIT       = 19'h40000
  } state_t;

  state_t state_r;
  in_item_t item_r;

  // configuration
  logic        effect_r;
  logic [7:0]  floor_r;
  logic [7:0]  swing_r;
  logic [9:0]  gap_r;
  logic [15:0] lfsr_r;
  logic [15:0] lfsr_nxt;

  // per-zone state
  logic        zone_ready_r [ZONE_COUNT];
  logic [15:0] main_ph_r    [ZONE_COUNT];
  logic [15:0] fast_ph_r    [ZONE_COUNT];
  logic [15:0] slow_ph_r    [ZONE_COUNT];
  logic [7:0]  speed_r      [ZONE_COUNT];
  logic [7:0]  base_r       [ZONE_COUNT];
  logic [15:0] smooth_r     [ZONE_COUNT];
  logic [31:0] repat_r      [ZONE_COUNT];
  logic [31:0] last_r       [ZONE_COUNT];

  // working registers of the current request
  logic               init_r;
  logic               run_r;
  logic [31:0]        dt_r;
  logic [39:0]        mul_r;
  logic signed [7:0]  noise_r;
  logic [2:0]         sub_r;
  logic signed [16:0] opnd_r;
  logic [16:0]        coef_r;
  logic signed [31:0] acc_r;
  logic signed [40:0] scale_r;
  logic [15:0]        tgt_r;

  // bit-serial divider, three lanes sharing one bit counter
  logic [63:0] dvd_r [3];
  logic [29:0] dvs_r [3];
  logic [29:0] rem_r [3];
  logic [15:0] quo_r [3];
  logic [6:0]  div_cnt_r;
  logic        div_busy_r;

  logic        div_go;
  logic [6:0]  div_len;
  logic [63:0] div_dvd [3];
  logic [29:0] div_dvs [3];
  logic        div_done;

  logic        out_valid_r;
  out_item_t   out_r;

  // combinational helpers
  logic [3:0]         slot;
  logic [31:0]        now;
  logic               slot_ok;
  logic [31:0]        dt_c;
  logic               is_draw;
  logic [10:0]        draw_n;
  logic [10:0]        draw_val;
  logic [8:0]         base_sum;
  logic [7:0]         base_sat;
  logic signed [16:0] term_val;
  logic [16:0]        term_coef;
  logic signed [34:0] sum_prod;
  logic signed [40:0] delta_c;
  logic signed [19:0] tsum_c;
  logic signed [19:0] hi_c;
  logic signed [19:0] lo_c;
  logic signed [19:0] tclip_c;
  logic signed [19:0] tfin_c;
  logic [19:0]        smooth_num;
  logic [63:0]        mul64;
  logic [16:0]        lvl_sum;
  logic [7:0]         lvl;
  logic [31:0]        rep_age;
  logic               rep_due;
  out_item_t          res_c;

  assign slot     = item_r.zone_slot;
  assign now      = item_r.now_ms;
  assign slot_ok  = int'(slot) < ZONE_COUNT;
  assign dt_c     = now - last_r[slot];
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign div_done  = run_r && !div_busy_r;
  assign draw_val  = rem_r[0][10:0];

  // Galois step of the noise register
  assign lfsr_nxt = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);

  assign base_sum = {1'b0, floor_r} + 9'(draw_val);
  assign base_sat = base_sum[8] ? 8'hFF : base_sum[7:0];
  // repattern once its time is reached, judged over half the wrapping clock
  assign rep_age  = now - repat_r[slot];
  assign rep_due  = !rep_age[31];

  always_comb begin
    case (state_r)
      ST_INIT_BASE:  draw_n = 11'd30;
      ST_INIT_PHASE: draw_n = 11'd628;
      ST_INIT_SPEED: draw_n = 11'd150;
      ST_INIT_REPAT: draw_n = 11'd1500;
      ST_NOISE:      draw_n = 11'd200;
      ST_REP_BASE:   draw_n = 11'd40;
      ST_REP_SPEED:  draw_n = 11'd150;
      ST_REP_TIME:   draw_n = 11'd2000;
      default:       draw_n = 11'd1;
    endcase
  end

  assign is_draw = (state_r == ST_INIT_BASE) || (state_r == ST_INIT_PHASE) ||
                   (state_r == ST_INIT_SPEED) || (state_r == ST_INIT_REPAT) ||
                   (state_r == ST_NOISE) || (state_r == ST_REP_BASE) ||
                   (state_r == ST_REP_SPEED) || (state_r == ST_REP_TIME);

  // flicker terms, one per pair of accumulate steps
  always_comb begin
    case (term_t'(sub_r[2:1]))
      TERM_MAIN: begin
        term_val  = sine_q15(main_ph_r[slot]);
        term_coef = W_MAIN;
      end
      TERM_FAST: begin
        term_val  = sine_q15(fast_ph_r[slot]);
        term_coef = W_FAST;
      end
      TERM_SLOW: begin
        term_val  = sine_q15(slow_ph_r[slot]);
        term_coef = W_SLOW;
      end
      TERM_NOISE: begin
        term_val  = 17'(noise_r);
        term_coef = W_NOISE;
      end
      default: begin
        term_val  = '0;
        term_coef = '0;
      end
    endcase
  end

  assign sum_prod = 35'(opnd_r) * $signed({18'd0, coef_r});

  // target: base plus rounded flicker, then clamp to [floor, ceiling]
  assign delta_c = (scale_r + 41'sd2097152) >>> 22;
  assign tsum_c  = $signed({4'd0, base_r[slot], 8'd0}) + 20'(delta_c);
  assign hi_c    = $signed({4'd0, item_r.ceiling, 8'd0});
  assign lo_c    = $signed({4'd0, floor_r, 8'd0});
  assign tclip_c = (tsum_c > hi_c) ? hi_c : tsum_c;
  assign tfin_c  = (tclip_c < lo_c) ? lo_c : tclip_c;

  assign smooth_num = 20'(smooth_r[slot]) * 20'd7 + 20'(tgt_r) * 20'd3 + 20'd5;
  assign mul64      = 64'(mul_r);

  // launch the divider
  always_comb begin
    div_go  = 1'b0;
    div_len = 7'd0;
    for (int l = 0; l < 3; l++) begin
      div_dvd[l] = '0;
      div_dvs[l] = '0;
    end
    if (is_draw && !run_r) begin
      div_go     = 1'b1;
      div_len    = 7'd16;
      div_dvd[0] = {lfsr_nxt, 48'd0};
      div_dvs[0] = 30'(draw_n);
    end else if (state_r == ST_SMOOTH && !run_r) begin
      div_go     = 1'b1;
      div_len    = 7'd20;
      div_dvd[0] = {smooth_num, 44'd0};
      div_dvs[0] = 30'd10;
    end else if (state_r == ST_PH_PREP) begin
      div_go  = 1'b1;
      div_len = 7'd64;
      if (init_r) begin
        div_dvd[0] = 64'(mul_r[9:0]) * INIT_K_MAIN + INIT_MAIN_BIAS;
        div_dvd[1] = 64'(mul_r[9:0]) * INIT_K_FAST + INIT_SLOW_BIAS;
        div_dvd[2] = 64'(mul_r[9:0]) * INIT_K_SLOW + INIT_SLOW_BIAS;
        div_dvs[0] = INIT_MAIN_DIV;
        div_dvs[1] = INIT_SLOW_DIV;
        div_dvs[2] = INIT_SLOW_DIV;
      end else begin
        div_dvd[0] = (mul64 << 16) + RUN_MAIN_BIAS;
        div_dvd[1] = ((mul64 * FAST_MULT) << 16) + RUN_SLOW_BIAS;
        div_dvd[2] = (mul64 << 18) + RUN_SLOW_BIAS;
        div_dvs[0] = RUN_MAIN_DIV;
        div_dvs[1] = RUN_SLOW_DIV;
        div_dvs[2] = RUN_SLOW_DIV;
      end
    end
  end

  // one restoring step per lane and cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (div_go) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= div_len;
    end else if (div_busy_r) begin
      div_cnt_r  <= div_cnt_r - 7'd1;
      div_busy_r <= (div_cnt_r != 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (div_go) begin
        dvd_r[l] <= div_dvd[l];
        dvs_r[l] <= div_dvs[l];
        rem_r[l] <= '0;
        quo_r[l] <= '0;
      end else if (div_busy_r) begin
        dvd_r[l] <= dvd_r[l] << 1;
        if ({rem_r[l], dvd_r[l][63]} >= {1'b0, dvs_r[l]}) begin
          rem_r[l] <= 30'({rem_r[l], dvd_r[l][63]} - {1'b0, dvs_r[l]});
          quo_r[l] <= {quo_r[l][14:0], 1'b1};
        end else begin
          rem_r[l] <= {rem_r[l][28:0], dvd_r[l][63]};
          quo_r[l] <= {quo_r[l][14:0], 1'b0};
        end
      end
    end
  end

  // result fields
  assign lvl_sum = 17'(smooth_r[slot]) + 17'd128;
  assign lvl     = lvl_sum[16] ? 8'hFF : lvl_sum[15:8];

  always_comb begin
    res_c.out_tag   = item_r.zone_tag;
    res_c.level     = lvl;
    res_c.has_color = item_r.zone_kind[0];
    res_c.red       = item_r.zone_kind[0] ? 8'hFF : 8'h00;
    res_c.green     = item_r.zone_kind[0] ? GREEN_TAB[lvl] : 8'h00;
    res_c.blue      = item_r.zone_kind[0] ? BLUE_TAB[lvl] : 8'h00;
  end

  // control: sequencer, configuration, noise register, valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
      effect_r    <= 1'b0;
      floor_r     <= FLOOR_RST;
      swing_r     <= SWING_RST;
      gap_r       <= GAP_RST;
      lfsr_r      <= SEED_RST;
      for (int z = 0; z < ZONE_COUNT; z++) zone_ready_r[z] <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_EMIT) out_valid_r <= 1'b0;
      if (div_go && is_draw) lfsr_r <= lfsr_nxt;
      if (div_go) run_r <= 1'b1;
      if (div_done) run_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!effect_r || !item_r.zone_on || !slot_ok) state_r <= ST_IDLE;
          else if (!zone_ready_r[slot]) state_r <= ST_INIT_BASE;
          else if (dt_c < 32'(gap_r)) state_r <= ST_IDLE;
          else state_r <= ST_UPD_MUL;
        end
        ST_INIT_BASE:  if (div_done) state_r <= ST_INIT_PHASE;
        ST_INIT_PHASE: if (div_done) state_r <= ST_PH_PREP;
        ST_INIT_SPEED: if (div_done) state_r <= ST_INIT_REPAT;
        ST_INIT_REPAT: begin
          if (div_done) begin
            zone_ready_r[slot] <= 1'b1;
            state_r            <= ST_IDLE;
          end
        end
        ST_UPD_MUL: state_r <= ST_PH_PREP;
        ST_PH_PREP: state_r <= ST_PH_DIV;
        ST_PH_DIV: begin
          if (div_done) state_r <= init_r ? ST_INIT_SPEED : ST_NOISE;
        end
        ST_NOISE: if (div_done) state_r <= ST_SUM;
        ST_SUM:   if (sub_r == 3'd7) state_r <= ST_SCALE;
        ST_SCALE:  state_r <= ST_TARGET;
        ST_TARGET: state_r <= ST_SMOOTH;
        ST_SMOOTH: begin
          if (div_done) state_r <= rep_due ? ST_REP_BASE : ST_FINISH;
        end
        ST_REP_BASE:  if (div_done) state_r <= ST_REP_SPEED;
        ST_REP_SPEED: if (div_done) state_r <= ST_REP_TIME;
        ST_REP_TIME:  if (div_done) state_r <= ST_FINISH;
        ST_FINISH: state_r <= item_r.zone_kind[1] ? ST_IDLE : ST_EMIT;
        ST_EMIT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_EFFECT_ON: begin
            if (cfg_wdata[0] && !effect_r) begin
              for (int z = 0; z < ZONE_COUNT; z++) zone_ready_r[z] <= 1'b0;
            end
            effect_r <= cfg_wdata[0];
          end
          REG_FLOOR: floor_r <= cfg_wdata[7:0];
          REG_SWING: swing_r <= cfg_wdata[7:0];
          REG_GAP:   gap_r   <= cfg_wdata[9:0];
          REG_SEED:  lfsr_r  <= (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload and zone state, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) item_r <= in_data;
    if (state_r == ST_EMIT && (!out_valid_r || out_ready)) out_r <= res_c;

    case (state_r)
      ST_CHECK: begin
        dt_r   <= dt_c;
        init_r <= !zone_ready_r[slot];
      end
      ST_INIT_BASE: begin
        if (div_done) begin
          base_r[slot]   <= base_sat;
          last_r[slot]   <= now;
          smooth_r[slot] <= {floor_r, 8'd0};
        end
      end
      ST_INIT_PHASE: if (div_done) mul_r <= 40'(draw_val);
      ST_INIT_SPEED: if (div_done) speed_r[slot] <= 8'(draw_val + 11'd50);
      ST_INIT_REPAT: if (div_done) repat_r[slot] <= now + 32'(draw_val) + 32'd500;
      ST_UPD_MUL: mul_r <= 40'(dt_r) * 40'(speed_r[slot]);
      ST_PH_DIV: begin
        if (div_done) begin
          main_ph_r[slot] <= init_r ? quo_r[0] : main_ph_r[slot] + quo_r[0];
          fast_ph_r[slot] <= init_r ? quo_r[1] : fast_ph_r[slot] + quo_r[1];
          slow_ph_r[slot] <= init_r ? quo_r[2] : slow_ph_r[slot] + quo_r[2];
        end
      end
      ST_NOISE: begin
        if (div_done) begin
          noise_r <= $signed(draw_val[7:0] - 8'd100);
          acc_r   <= '0;
          sub_r   <= '0;
        end
      end
      ST_SUM: begin
        // even step: fetch term, odd step: accumulate weighted term
        if (!sub_r[0]) begin
          opnd_r <= term_val;
          coef_r <= term_coef;
        end else begin
          acc_r <= acc_r + 32'(sum_prod);
        end
        sub_r <= sub_r + 3'd1;
      end
      ST_SCALE:  scale_r <= 41'(acc_r) * $signed({33'd0, swing_r});
      ST_TARGET: tgt_r   <= tfin_c[15:0];
      ST_SMOOTH: if (div_done) smooth_r[slot] <= quo_r[0];
      ST_REP_BASE:  if (div_done) base_r[slot]  <= base_sat;
      ST_REP_SPEED: if (div_done) speed_r[slot] <= 8'(draw_val + 11'd50);
      ST_REP_TIME:  if (div_done) repat_r[slot] <= now + 32'(draw_val) + 32'd1000;
      ST_FINISH: last_r[slot] <= now;
      default: ;
    endcase
  end

endmodule

/* rtl/core/lcf_checker.sv */
// Port-level checks of the candle flicker block, bound to its top level.
`include "assert_macros.svh"

module lcf_checker import lcf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // one request at a time: drop ready right after an accept
  `LCF_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "in_ready stayed high after accept")

  // a stalled result holds
  `LCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // RGB results carry full red
  `LCF_ASSERT(a_rgb_red, clk, rst_n, out_valid && out_data.has_color |-> out_data.red == 8'hFF, "RGB result without full red")

  // PWM results carry no color
  `LCF_ASSERT(a_pwm_dark, clk, rst_n, out_valid && !out_data.has_color |-> out_data.red == 8'h00 && out_data.green == 8'h00 && out_data.blue == 8'h00, "PWM result with color")

endmodule

bind led_candle_flicker lcf_checker u_lcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/led_candle_flicker_tb.sv */
// Self-checking testbench of the candle flicker engine: predicted levels against the block.
module led_candle_flicker_tb;
  import lcf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 250;

  // Predicts the result of every accepted request and holds it until it comes out.
  class flicker_board;
    bit              fx_on;
    bit [7:0]        floor_lv;
    bit [7:0]        swing_lv;
    bit [9:0]        gap_ms;
    bit [15:0]       lfsr;
    bit              ready_z [16];
    bit [15:0]       ph_main [16];
    bit [15:0]       ph_fast [16];
    bit [15:0]       ph_slow [16];
    bit [7:0]        speed_z [16];
    bit [7:0]        base_z  [16];
    bit [15:0]       smooth_z[16];
    bit [31:0]       repat_z [16];
    bit [31:0]       last_z  [16];
    int              quarter [SINE_TABLE_DEPTH+1];
    out_item_t       pending_levels[$];
    int              err_count;

    function new();
      longint unsigned z, z2, t, s;
      fx_on = 0; floor_lv = 20; swing_lv = 100; gap_ms = 20; lfsr = 16'd44257;
      err_count = 0;
      for (int i = 0; i < 16; i++) begin
        ready_z[i] = 0; ph_main[i] = 0; ph_fast[i] = 0; ph_slow[i] = 0;
      end
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
        z  = (longint'(i) * 65536) / SINE_TABLE_DEPTH;
        z2 = (z * z) >> 16;
        t  = 172272;
        t  = 5026995    - ((z2 * t) >> 16);
        t  = 85569306   - ((z2 * t) >> 16);
        t  = 693598667  - ((z2 * t) >> 16);
        t  = 1686629713 - ((z2 * t) >> 16);
        s  = (((z * t) >> 16) + 16384) >> 15;
        quarter[i] = (s > 32767) ? 32767 : int'(s);
      end
    endfunction

    function void write_reg(cfg_reg_t idx, bit [15:0] val);
      case (idx)
        REG_EFFECT_ON: begin
          if (val[0] && !fx_on) foreach (ready_z[i]) ready_z[i] = 0;
          fx_on = val[0];
        end
        REG_FLOOR: floor_lv = val[7:0];
        REG_SWING: swing_lv = val[7:0];
        REG_GAP:   gap_ms = val[9:0];
        REG_SEED:  lfsr = (val == 0) ? 16'd1 : val;
        default: ;
      endcase
    endfunction

    // Advance the noise register, then pick lo + lfsr mod n.
    function int pick(int n, int lo);
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
      return lo + int'(lfsr % n);
    endfunction

    function longint sine(bit [15:0] ph);
      int idx, v;
      idx = (int'(ph[13:0]) * SINE_TABLE_DEPTH) >> 14;
      v = ph[14] ? quarter[SINE_TABLE_DEPTH - idx] : quarter[idx];
      return ph[15] ? -longint'(v) : longint'(v);
    endfunction

    function bit [7:0] sat8(int v);
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function void note_tick(in_item_t it);
      int              s, p;
      longint unsigned q, n, u;
      longint          flick, target, lo, hi;
      bit [31:0]       dt;
      int              lv;
      out_item_t       r;
      s = int'(it.zone_slot);
      if (!fx_on || !it.zone_on) return;
      if (!ready_z[s]) begin
        last_z[s]   = it.now_ms;
        smooth_z[s] = {floor_lv, 8'd0};
        base_z[s]   = sat8(int'(floor_lv) + pick(30, 0));
        p = pick(628, 0);
        q = longint'(p) * 65536 * 100000;
        ph_main[s]  = 16'((q + 31415926) / 62831853);
        ph_fast[s]  = 16'((q * 73 + 314159265) / 628318530);
        ph_slow[s]  = 16'((q * 4 + 314159265) / 628318530);
        speed_z[s]  = 8'(pick(150, 50));
        repat_z[s]  = it.now_ms + 32'(pick(1500, 500));
        ready_z[s]  = 1;
        return;
      end
      dt = it.now_ms - last_z[s];
      if (dt < gap_ms) return;
      n = longint'(dt) * speed_z[s] * 65536;
      ph_main[s] += 16'((n + 100000) / 200000);
      ph_fast[s] += 16'((n * 73 + 1000000) / 2000000);
      ph_slow[s] += 16'((n * 4 + 1000000) / 2000000);
      flick = 9830 * sine(ph_main[s]) + 4915 * sine(ph_fast[s]) + 6554 * sine(ph_slow[s])
            + longint'(pick(200, -100)) * 107374;
      u = longint'(flick * longint'(swing_lv) + (longint'(1) << 40));
      target = longint'(base_z[s]) * 256 + longint'((u + (64'd1 << 21)) >> 22)
             - (longint'(1) << 18);
      hi = longint'(it.ceiling) * 256;
      lo = longint'(floor_lv) * 256;
      if (target > hi) target = hi;
      if (target < lo) target = lo;
      smooth_z[s] = 16'((longint'(smooth_z[s]) * 7 + target * 3 + 5) / 10);
      if (it.now_ms - repat_z[s] < 32'h8000_0000) begin
        base_z[s]  = sat8(int'(floor_lv) + pick(40, 0));
        speed_z[s] = 8'(pick(150, 50));
        repat_z[s] = it.now_ms + 32'(pick(2000, 1000));
      end
      last_z[s] = it.now_ms;
      lv = (int'(smooth_z[s]) + 128) >> 8;
      if (lv > 255) lv = 255;
      if (it.zone_kind > 1) return;
      r.out_tag   = it.zone_tag;
      r.level     = lv[7:0];
      r.has_color = it.zone_kind[0];
      r.red       = it.zone_kind[0] ? 8'd255 : 8'd0;
      r.green     = it.zone_kind[0] ? 8'(60 + lv * 120 / 255) : 8'd0;
      r.blue      = it.zone_kind[0] ? 8'(lv * 30 / 255) : 8'd0;
      pending_levels.push_back(r);
    endfunction

    function void check_level(out_item_t got);
      out_item_t w;
      if (pending_levels.size() == 0) begin
        $error("unexpected result tag=%0d level=%0d", got.out_tag, got.level);
        err_count++;
        return;
      end
      w = pending_levels.pop_front();
      if (got.out_tag != w.out_tag) begin
        $error("out_tag: expected %0d, got %0d", w.out_tag, got.out_tag); err_count++;
      end
      if (got.level != w.level) begin
        $error("level: expected %0d, got %0d", w.level, got.level); err_count++;
      end
      if (got.has_color != w.has_color) begin
        $error("has_color: expected %0d, got %0d", w.has_color, got.has_color); err_count++;
      end
      if (got.red != w.red) begin
        $error("red: expected %0d, got %0d", w.red, got.red); err_count++;
      end
      if (got.green != w.green) begin
        $error("green: expected %0d, got %0d", w.green, got.green); err_count++;
      end
      if (got.blue != w.blue) begin
        $error("blue: expected %0d, got %0d", w.blue, got.blue); err_count++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_valid = 0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 0;
  out_item_t            out_data;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  flicker_board board = new();
  int           cycles = 0;
  int           burst_left = 0;
  bit [31:0]    zone_clock[16];   // running time of each zone

  led_candle_flicker u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: stall on its own pattern, with long clean stretches, and check
  // every result taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_level(out_data);
    if ((cycles / 400) % 3 == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Send one request; hold valid and payload until accepted, then maybe start a gap.
  task automatic send_tick(in_item_t it);
    int gap_len;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_tick(it);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 20);
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  // Advance one zone's clock and send a tick for it.
  task automatic tick(int slot, bit [31:0] dt, bit [1:0] kind, bit [7:0] ceil_v,
                      bit on, bit [7:0] tag);
    in_item_t it;
    zone_clock[slot] += dt;
    it.zone_slot = slot[3:0];
    it.zone_tag  = tag;
    it.now_ms    = zone_clock[slot];
    it.zone_on   = on;
    it.ceiling   = ceil_v;
    it.zone_kind = kind;
    send_tick(it);
  endtask

  // Drop valid and wait for every pending result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, bit [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  // Load a full setting and restart the effect so every zone is set up again.
  task automatic setup(bit [7:0] fl, bit [7:0] sw, bit [9:0] gp, bit [15:0] seed);
    write_cfg(REG_EFFECT_ON, 16'd0);
    write_cfg(REG_FLOOR, {8'd0, fl});
    write_cfg(REG_SWING, {8'd0, sw});
    write_cfg(REG_GAP, {6'd0, gp});
    write_cfg(REG_SEED, seed);
    write_cfg(REG_EFFECT_ON, 16'd1);
    foreach (zone_clock[i]) zone_clock[i] = $urandom;
  endtask

  // Random ticks: mostly well-spaced updates, some too early, some long jumps.
  task automatic random_ticks(int count, int gp);
    int        sel;
    bit [31:0] dt;
    bit [1:0]  kind;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70)      dt = $urandom_range(gp, 3 * gp);
      else if (sel < 85) dt = $urandom_range(0, gp - 1);
      else if (sel < 95) dt = $urandom_range(0, 5000);
      else               dt = $urandom;
      kind = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
      tick($urandom_range(0, 15), dt, kind, 8'($urandom), $urandom_range(0, 9) != 0,
           8'($urandom));
      if (k == count / 2) drain();   // hold off once until the block is empty
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: effect off, zone off, set-up, early tick, kinds, clamps, wrap, repattern.
    foreach (zone_clock[i]) zone_clock[i] = 32'h0000_1000;
    tick(0, 0, 2'd0, 8'd255, 1'b1, 8'd0);          // effect still off
    drain();
    write_cfg(REG_EFFECT_ON, 16'd1);
    tick(0, 0, 2'd0, 8'd255, 1'b0, 8'd1);          // zone off
    tick(0, 0, 2'd1, 8'd255, 1'b1, 8'd2);          // set-up tick
    tick(0, 5, 2'd1, 8'd255, 1'b1, 8'd3);          // gap not passed
    tick(0, 20, 2'd0, 8'd255, 1'b1, 8'd0);
    tick(0, 25, 2'd1, 8'd255, 1'b1, 8'd255);
    tick(0, 30, 2'd2, 8'd255, 1'b1, 8'd4);
    tick(0, 30, 2'd3, 8'd255, 1'b1, 8'd5);
    tick(0, 30, 2'd1, 8'd0, 1'b1, 8'd6);           // ceiling below floor
    tick(0, 3000, 2'd1, 8'd128, 1'b1, 8'd7);       // repattern due
    zone_clock[15] = 32'hFFFF_FFF0;
    tick(15, 0, 2'd1, 8'd255, 1'b1, 8'd8);         // set-up just before the wrap
    tick(15, 40, 2'd1, 8'd255, 1'b1, 8'd9);        // time wraps through zero
    tick(15, 32'h8000_0000, 2'd0, 8'd255, 1'b1, 8'd10);
    tick(15, 32'hFFFF_FFFF, 2'd1, 8'd255, 1'b1, 8'd11);
    drain();
    setup(8'd255, 8'd255, 10'd1, 16'd0);           // base saturates, zero seed
    for (int s = 0; s < 4; s++) tick(s, 0, 2'd1, 8'd255, 1'b1, 8'(s));
    for (int s = 0; s < 4; s++) tick(s, 1, 2'(s % 2), 8'(s * 80), 1'b1, 8'(s));
    drain();

    // Random phases over a sweep of settings, extremes included.
    setup(8'd20, 8'd100, 10'd20, 16'd44257);   random_ticks(100, 20);   drain();
    setup(8'd0, 8'd255, 10'd1, 16'd1);         random_ticks(100, 1);    drain();
    setup(8'd255, 8'd0, 10'd1000, 16'd65535);  random_ticks(100, 1000); drain();
    setup(8'd50, 8'd200, 10'd5, 16'd0);        random_ticks(100, 5);    drain();
    setup(8'($urandom_range(0, 120)), 8'($urandom), 10'd50, 16'($urandom));
    random_ticks(100, 50);
    drain();
    setup(8'($urandom), 8'($urandom), 10'($urandom_range(1, 1000)), 16'($urandom));
    random_ticks(100, 30);
    drain();

    if (board.err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
